// ----- rtl/isod_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isod_pkg
// Shared types, constants and helper functions of the ISODATA binarizer.
// ----------------------------------------------------------------------------
package isod_pkg;

    localparam int PIXEL_BITS   = 16;
    localparam int IMAGE_DEPTH  = 65536;
    localparam int ADDR_BITS    = 16;
    localparam int COUNT_BITS   = 17;
    localparam int MAX_CHANNELS = 4;
    localparam int CH_BITS      = 2;
    localparam int NCH_BITS     = 3;
    localparam int SUM_BITS     = 32;
    localparam int ITER_BITS    = 8;
    localparam int DIVISOR_BITS = COUNT_BITS + 1;

    localparam logic REG_CHANNEL_COUNT   = 1'b0;
    localparam logic REG_ITERATION_LIMIT = 1'b1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic RES_REPORT = 1'b0;
    localparam logic RES_PIXEL  = 1'b1;

    localparam logic CLS_BACK = 1'b0;
    localparam logic CLS_OBJ  = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [PIXEL_BITS-1:0] pixel_value;
        logic                  last_pixel;
        logic [ADDR_BITS-1:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic                  result_kind;
        logic [PIXEL_BITS-1:0] threshold_ch0;
        logic [PIXEL_BITS-1:0] threshold_ch1;
        logic [PIXEL_BITS-1:0] threshold_ch2;
        logic [PIXEL_BITS-1:0] threshold_ch3;
        logic [ITER_BITS-1:0]  passes_used;
        logic                  converged;
        logic                  object_bit;
        logic                  index_valid;
    } t_out_item;

    typedef struct packed {
        logic                 load;
        logic                 rd;
        logic                 clear_img;
        logic                 init_thr;
        logic                 scan_start;
        logic                 div_start;
        logic                 div_cls;
        logic [CH_BITS-1:0]   ch;
        logic                 thr_write;
        logic                 report;
        logic                 conv;
        logic [ITER_BITS-1:0] passes;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic changed;
    } t_dp_stat;

    // Register value 0 acts as one channel, anything above the maximum saturates.
    function automatic logic [NCH_BITS-1:0] eff_channels(input logic [NCH_BITS-1:0] cfg);
        logic [NCH_BITS-1:0] n;
        n = cfg;
        if (cfg == '0) begin
            n = NCH_BITS'(1);
        end else if (cfg > NCH_BITS'(MAX_CHANNELS)) begin
            n = NCH_BITS'(MAX_CHANNELS);
        end
        return n;
    endfunction

    // Residue mod 3 by folding base-4 digits, since 4 is 1 mod 3.
    function automatic logic [CH_BITS-1:0] mod3(input logic [ADDR_BITS-1:0] v);
        logic [4:0] s;
        logic [3:0] s2;
        logic [2:0] s3;
        s = '0;
        for (int k = 0; k < ADDR_BITS / 2; k++) begin
            s = s + 5'(v[2*k +: 2]);
        end
        s2 = 4'(s[4:2]) + 4'(s[1:0]);
        s3 = 3'(s2[3:2]) + 3'(s2[1:0]);
        if (s3 >= 3'd3) begin
            s3 = s3 - 3'd3;
        end
        return s3[1:0];
    endfunction

    function automatic logic [CH_BITS-1:0] chan_of(input logic [ADDR_BITS-1:0] v,
                                                  input logic [NCH_BITS-1:0] nch);
        logic [CH_BITS-1:0] c;
        case (nch)
            3'd2:    c = {1'b0, v[0]};
            3'd3:    c = mod3(v);
            3'd4:    c = v[1:0];
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/isod_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isod_div
// Restoring divider, one quotient bit per cycle, for class mean terms.
// ----------------------------------------------------------------------------
module isod_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [isod_pkg::SUM_BITS-1:0]       i_dividend,
    input  wire logic [isod_pkg::DIVISOR_BITS-1:0]   i_divisor,
    output logic      [isod_pkg::PIXEL_BITS-1:0]     o_quot,
    output logic                                     o_done
);
    localparam int CNT_BITS = $clog2(isod_pkg::SUM_BITS);

    logic                              r_busy;
    logic                              r_done;
    logic [CNT_BITS-1:0]               r_cnt;
    logic [isod_pkg::DIVISOR_BITS-1:0] r_rem;
    logic [isod_pkg::DIVISOR_BITS-1:0] r_den;
    logic [isod_pkg::SUM_BITS-1:0]     r_quo;
    logic [isod_pkg::DIVISOR_BITS:0]   trial;
    logic                              ge;

    assign trial = {r_rem, r_quo[isod_pkg::SUM_BITS-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(isod_pkg::SUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? isod_pkg::DIVISOR_BITS'(trial - {1'b0, r_den})
                        : isod_pkg::DIVISOR_BITS'(trial);
            r_quo <= {r_quo[isod_pkg::SUM_BITS-2:0], ge};
        end
    end

    assign o_quot = r_quo[isod_pkg::PIXEL_BITS-1:0];
    assign o_done = r_done;
endmodule
`default_nettype wire

// ----- rtl/isod_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isod_dp
// Datapath: pixel memory, channel statistics, pass accumulators and results.
// ----------------------------------------------------------------------------
module isod_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire isod_pkg::t_in_item                i_item,
    input  wire logic [isod_pkg::NCH_BITS-1:0]     i_nch,
    input  wire isod_pkg::t_dp_cmd                 i_cmd,
    output isod_pkg::t_dp_stat                     o_stat,
    output logic                                   o_result_valid,
    output isod_pkg::t_out_item                    o_result
);
    localparam int PB = isod_pkg::PIXEL_BITS;
    localparam int NC = isod_pkg::MAX_CHANNELS;
    localparam int CB = isod_pkg::CH_BITS;

    logic [PB-1:0] mem [0:isod_pkg::IMAGE_DEPTH-1];
    logic [PB-1:0] r_rdata;

    logic [isod_pkg::COUNT_BITS-1:0] r_loaded_count;
    logic [PB-1:0] r_min [NC];
    logic [PB-1:0] r_max [NC];
    logic [PB-1:0] r_thr [NC];
    logic [isod_pkg::SUM_BITS-1:0]   r_bsum [NC];
    logic [isod_pkg::SUM_BITS-1:0]   r_osum [NC];
    logic [isod_pkg::COUNT_BITS-1:0] r_bcnt [NC];
    logic [isod_pkg::COUNT_BITS-1:0] r_ocnt [NC];

    logic                            r_scan_on;
    logic [isod_pkg::COUNT_BITS-1:0] r_addr;
    logic [CB-1:0]                   r_sch;
    logic                            r_acc_v;
    logic [CB-1:0]                   r_ach;
    logic                            r_changed;

    logic                            r_rd_v;
    logic                            r_rd_iv;
    logic [CB-1:0]                   r_rd_ch;

    logic                            r_div_zero;
    logic                            r_div_cls;
    logic [PB-1:0]                   r_nxt;

    logic                            r_out_valid;
    isod_pkg::t_out_item             r_out;

    logic [isod_pkg::COUNT_BITS-1:0] eff_count;
    logic [CB-1:0]                   ld_ch;
    logic                            ld_ok;
    logic [PB-1:0]                   ld_v;
    logic [isod_pkg::ADDR_BITS-1:0]  raddr;
    logic [CB-1:0]                   thr_addr;
    logic [PB-1:0]                   thr_rd;
    logic [CB-1:0]                   scan_nxt_ch;
    logic [isod_pkg::SUM_BITS-1:0]   div_dividend;
    logic [isod_pkg::COUNT_BITS-1:0] div_count;
    logic [PB-1:0]                   div_q;
    logic                            div_done;
    logic [PB-1:0]                   add_term;

    function automatic logic [isod_pkg::NCH_BITS-1:0] NCH_BITS_EXT(input logic [CB-1:0] c);
        return isod_pkg::NCH_BITS'(c);
    endfunction

    assign eff_count = i_cmd.clear_img ? '0 : r_loaded_count;
    assign ld_ok     = eff_count < isod_pkg::COUNT_BITS'(isod_pkg::IMAGE_DEPTH);
    assign ld_ch     = isod_pkg::chan_of(eff_count[isod_pkg::ADDR_BITS-1:0], i_nch);
    assign ld_v      = i_item.pixel_value;
    assign raddr     = r_scan_on ? r_addr[isod_pkg::ADDR_BITS-1:0] : i_item.read_index;

    // The threshold file has a single read port shared by all users.
    assign thr_addr  = i_cmd.thr_write ? i_cmd.ch : (r_acc_v ? r_ach : r_rd_ch);
    assign thr_rd    = r_thr[thr_addr];

    assign scan_nxt_ch = (NCH_BITS_EXT(r_sch) + 3'd1 >= i_nch) ? '0 : r_sch + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && ld_ok) begin
            mem[eff_count[isod_pkg::ADDR_BITS-1:0]] <= ld_v;
        end
        r_rdata <= mem[raddr];
    end

    assign div_dividend = (i_cmd.div_cls == isod_pkg::CLS_OBJ) ? r_osum[i_cmd.ch]
                                                                : r_bsum[i_cmd.ch];
    assign div_count    = (i_cmd.div_cls == isod_pkg::CLS_OBJ) ? r_ocnt[i_cmd.ch]
                                                                : r_bcnt[i_cmd.ch];

    isod_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  ({div_count, 1'b0}),
        .o_quot     (div_q),
        .o_done     (div_done)
    );

    // An empty class contributes nothing to the next threshold.
    assign add_term = r_div_zero ? '0 : div_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded_count <= '0;
            r_scan_on      <= 1'b0;
            r_acc_v        <= 1'b0;
            r_rd_v         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_changed      <= 1'b0;
            r_addr         <= '0;
            r_sch          <= '0;
            for (int c = 0; c < NC; c++) begin
                r_min[c]  <= '1;
                r_max[c]  <= '0;
                r_thr[c]  <= '0;
                r_bsum[c] <= '0;
                r_osum[c] <= '0;
                r_bcnt[c] <= '0;
                r_ocnt[c] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                if (i_cmd.clear_img) begin
                    for (int c = 0; c < NC; c++) begin
                        r_min[c] <= '1;
                        r_max[c] <= '0;
                    end
                end
                r_loaded_count <= eff_count;
                if (ld_ok) begin
                    r_loaded_count <= eff_count + 1'b1;
                    if (ld_v < (i_cmd.clear_img ? {PB{1'b1}} : r_min[ld_ch])) begin
                        r_min[ld_ch] <= ld_v;
                    end
                    if (ld_v > (i_cmd.clear_img ? {PB{1'b0}} : r_max[ld_ch])) begin
                        r_max[ld_ch] <= ld_v;
                    end
                end
            end

            if (i_cmd.init_thr) begin
                for (int c = 0; c < NC; c++) begin
                    r_thr[c] <= (isod_pkg::NCH_BITS'(c) < i_nch)
                        ? PB'(({1'b0, r_min[c]} + {1'b0, r_max[c]}) >> 1) : '0;
                end
            end

            if (i_cmd.scan_start) begin
                r_scan_on <= 1'b1;
                r_addr    <= '0;
                r_sch     <= '0;
                r_changed <= 1'b0;
                for (int c = 0; c < NC; c++) begin
                    r_bsum[c] <= '0;
                    r_osum[c] <= '0;
                    r_bcnt[c] <= '0;
                    r_ocnt[c] <= '0;
                end
            end else if (r_scan_on) begin
                r_addr <= r_addr + 1'b1;
                r_sch  <= scan_nxt_ch;
                if (r_addr == r_loaded_count - 1'b1) begin
                    r_scan_on <= 1'b0;
                end
            end
            r_acc_v <= r_scan_on && !i_cmd.scan_start;
            r_ach   <= r_sch;

            if (r_acc_v) begin
                if (r_rdata < thr_rd) begin
                    r_bcnt[r_ach] <= r_bcnt[r_ach] + 1'b1;
                    r_bsum[r_ach] <= r_bsum[r_ach] + isod_pkg::SUM_BITS'(r_rdata);
                end else begin
                    r_ocnt[r_ach] <= r_ocnt[r_ach] + 1'b1;
                    r_osum[r_ach] <= r_osum[r_ach] + isod_pkg::SUM_BITS'(r_rdata);
                end
            end

            if (i_cmd.thr_write) begin
                r_thr[i_cmd.ch] <= r_nxt;
                if (r_nxt != thr_rd) begin
                    r_changed <= 1'b1;
                end
            end

            r_rd_v      <= i_cmd.rd;
            r_out_valid <= r_rd_v || i_cmd.report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_iv <= isod_pkg::COUNT_BITS'(i_item.read_index) < r_loaded_count;
            r_rd_ch <= isod_pkg::chan_of(i_item.read_index, i_nch);
        end
        if (i_cmd.div_start) begin
            r_div_zero <= div_count == '0;
            r_div_cls  <= i_cmd.div_cls;
        end
        if (div_done) begin
            r_nxt <= ((r_div_cls == isod_pkg::CLS_BACK) ? '0 : r_nxt) + add_term;
        end
        r_out <= '0;
        if (i_cmd.report) begin
            r_out.result_kind   <= isod_pkg::RES_REPORT;
            r_out.threshold_ch0 <= r_thr[0];
            r_out.threshold_ch1 <= r_thr[1];
            r_out.threshold_ch2 <= r_thr[2];
            r_out.threshold_ch3 <= r_thr[3];
            r_out.passes_used   <= i_cmd.passes;
            r_out.converged     <= i_cmd.conv;
        end else if (r_rd_v) begin
            r_out.result_kind <= isod_pkg::RES_PIXEL;
            r_out.index_valid <= r_rd_iv;
            r_out.object_bit  <= r_rd_iv && (r_rdata >= thr_rd);
        end
    end

    assign o_stat.scan_done = !r_scan_on && !r_acc_v;
    assign o_stat.div_done  = div_done;
    assign o_stat.changed   = r_changed;
    assign o_result_valid   = r_out_valid;
    assign o_result         = r_out;
endmodule
`default_nettype wire

// ----- rtl/isod_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isod_ctrl
// Controller: sequences loads, reads and the ISODATA refinement passes.
// ----------------------------------------------------------------------------
module isod_ctrl (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire isod_pkg::t_in_item                 i_item,
    input  wire logic [isod_pkg::NCH_BITS-1:0]      i_nch,
    input  wire logic [isod_pkg::ITER_BITS-1:0]     i_limit,
    input  wire isod_pkg::t_dp_stat                 i_stat,
    output isod_pkg::t_dp_cmd                       o_cmd,
    output logic                                    o_busy
);
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INIT   = 4'd1;
    localparam logic [3:0] ST_PSTART = 4'd2;
    localparam logic [3:0] ST_SCAN   = 4'd3;
    localparam logic [3:0] ST_DSTART = 4'd4;
    localparam logic [3:0] ST_DWAIT  = 4'd5;
    localparam logic [3:0] ST_TWRITE = 4'd6;
    localparam logic [3:0] ST_PEND   = 4'd7;
    localparam logic [3:0] ST_REPORT = 4'd8;

    localparam int IB = isod_pkg::ITER_BITS;

    logic [3:0]                  r_state, n_state;
    logic                        r_image_done, n_image_done;
    logic [IB-1:0]               r_passes, n_passes;
    logic                        r_conv, n_conv;
    logic [isod_pkg::CH_BITS-1:0] r_ch, n_ch;
    logic                        r_cls, n_cls;
    logic [IB:0]                 pass_next;
    logic [IB:0]                 limit_eff;
    logic                        accept;

    assign accept    = i_start && (r_state == ST_IDLE);
    assign pass_next = {1'b0, r_passes} + 1'b1;
    assign limit_eff = (i_limit == '0) ? (IB+1)'(1) : {1'b0, i_limit};

    always_comb begin
        n_state      = r_state;
        n_image_done = r_image_done;
        n_passes     = r_passes;
        n_conv       = r_conv;
        n_ch         = r_ch;
        n_cls        = r_cls;
        o_cmd        = '0;
        o_cmd.ch     = r_ch;
        o_cmd.div_cls = r_cls;
        o_cmd.conv   = r_conv;
        o_cmd.passes = r_passes;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_item.kind == isod_pkg::KIND_READ) begin
                        o_cmd.rd = 1'b1;
                    end else begin
                        o_cmd.load      = 1'b1;
                        o_cmd.clear_img = r_image_done;
                        n_image_done    = 1'b0;
                        if (i_item.last_pixel) begin
                            n_state = ST_INIT;
                        end
                    end
                end
            end
            ST_INIT: begin
                o_cmd.init_thr = 1'b1;
                n_passes       = '0;
                n_conv         = 1'b0;
                n_state        = ST_PSTART;
            end
            ST_PSTART: begin
                o_cmd.scan_start = 1'b1;
                n_state          = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_ch    = '0;
                    n_cls   = isod_pkg::CLS_BACK;
                    n_state = ST_DSTART;
                end
            end
            ST_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (i_stat.div_done) begin
                    if (r_cls == isod_pkg::CLS_OBJ) begin
                        n_state = ST_TWRITE;
                    end else begin
                        n_cls   = isod_pkg::CLS_OBJ;
                        n_state = ST_DSTART;
                    end
                end
            end
            ST_TWRITE: begin
                o_cmd.thr_write = 1'b1;
                if (isod_pkg::NCH_BITS'(r_ch) + 3'd1 >= i_nch) begin
                    n_state = ST_PEND;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_cls   = isod_pkg::CLS_BACK;
                    n_state = ST_DSTART;
                end
            end
            ST_PEND: begin
                n_passes = pass_next[IB-1:0];
                if (!i_stat.changed) begin
                    n_conv  = 1'b1;
                    n_state = ST_REPORT;
                end else if (pass_next >= limit_eff) begin
                    n_state = ST_REPORT;
                end else begin
                    n_state = ST_PSTART;
                end
            end
            ST_REPORT: begin
                o_cmd.report = 1'b1;
                n_image_done = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_image_done <= 1'b0;
            r_passes     <= '0;
            r_conv       <= 1'b0;
            r_ch         <= '0;
            r_cls        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_image_done <= n_image_done;
            r_passes     <= n_passes;
            r_conv       <= n_conv;
            r_ch         <= n_ch;
            r_cls        <= n_cls;
        end
    end

    assign o_busy = r_state != ST_IDLE;
endmodule
`default_nettype wire

// ----- rtl/isodata_threshold_binarizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isodata_threshold_binarizer
// ISODATA per-channel thresholding of a stored interleaved image.
// ----------------------------------------------------------------------------
// Load transactions can follow back to back. Read transactions can follow back to
// back; each answer passes the memory read register, then the result register.
// The last pixel starts the passes: each pass is a memory scan, then per channel
// two divisions (background, then object) and a threshold write, and one check.
// Busy holds meanwhile. Reset is synchronous; the receiver cannot stall results.
module isodata_threshold_binarizer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    output logic                                    o_busy,
    input  wire isod_pkg::t_in_item                 i_item,
    output logic                                    o_result_valid,
    output isod_pkg::t_out_item                     o_result,
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_index,
    input  wire logic [isod_pkg::ITER_BITS-1:0]     i_cfg_data
);
    logic [isod_pkg::NCH_BITS-1:0]  r_channel_count;
    logic [isod_pkg::ITER_BITS-1:0] r_iteration_limit;
    logic [isod_pkg::NCH_BITS-1:0]  nch;
    isod_pkg::t_dp_cmd              cmd;
    isod_pkg::t_dp_stat             stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count   <= isod_pkg::NCH_BITS'(1);
            r_iteration_limit <= isod_pkg::ITER_BITS'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                isod_pkg::REG_CHANNEL_COUNT:
                    r_channel_count <= i_cfg_data[isod_pkg::NCH_BITS-1:0];
                isod_pkg::REG_ITERATION_LIMIT:
                    r_iteration_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign nch = isod_pkg::eff_channels(r_channel_count);

    isod_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_item  (i_item),
        .i_nch   (nch),
        .i_limit (r_iteration_limit),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    isod_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_nch          (nch),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );
endmodule
`default_nettype wire
